FILE: rtl/byte_budget_lru_cache_core_assert.svh
// assertion macros for the byte budget lru cache checker
`ifndef BYTE_BUDGET_LRU_CACHE_CORE_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBLRU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BBLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bblru_pkg.sv
// shared constants, word types and state codes of the byte budget lru cache
package bblru_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int SIZE_W   = 24;
    localparam int HANDLE_W = 32;
    localparam int TOTAL_W  = 32;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_TRIM   = MODE_W'(3);

    localparam logic [KIND_W-1:0] KIND_LOOKUP  = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_REMOVED = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_DONE    = KIND_W'(2);

    localparam logic [REG_IDX_W-1:0] REG_MAX_BYTES   = REG_IDX_W'(0);
    localparam logic [TOTAL_W-1:0]   MAX_BYTES_RESET = '1;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [KEY_W-1:0]    frame_number;
        logic [SIZE_W-1:0]   frame_bytes;
        logic [HANDLE_W-1:0] frame_handle;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                hit;
        logic [KEY_W-1:0]    key_out;
        logic [HANDLE_W-1:0] handle_out;
        logic [TOTAL_W-1:0]  total_bytes;
        logic                last;
    } out_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
    } ram_req_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_ROT,
        ST_FLUSH,
        ST_PLACE,
        ST_TRIM_CHK,
        ST_TRIM_EV
    } state_t;

endpackage

FILE: rtl/bblru_ram.sv
// generic simple dual-port ram with registered read
module bblru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/bblru_cfg.sv
// apb register bank holding the byte budget
module bblru_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bblru_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bblru_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bblru_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic [bblru_pkg::TOTAL_W-1:0]      max_bytes
);
    import bblru_pkg::*;

    logic [TOTAL_W-1:0]   max_bytes_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_MAX_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (wr_en)
        begin
            max_bytes_reg <= pwdata[TOTAL_W-1:0];
        end
    end

    // unmapped addresses read as zero
    assign prdata    = (reg_idx == REG_MAX_BYTES) ? APB_DATA_W'(max_bytes_reg) : '0;
    assign max_bytes = max_bytes_reg;

endmodule

FILE: rtl/bblru_ctrl.sv
// sequencer walking the recency-ordered entry memory
module bblru_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bblru_pkg::in_word_t           cmd,
    output logic                          busy,
    input  logic [bblru_pkg::TOTAL_W-1:0] max_bytes,
    output bblru_pkg::ram_req_t           ram_req,
    input  logic [bblru_pkg::ENTRY_W-1:0] ram_rdata,
    output bblru_pkg::res_t               res
);
    import bblru_pkg::*;

    state_t             state_reg, state_next;
    in_word_t           cmd_reg, cmd_next;
    entry_t             ent_reg, ent_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               grow_reg, grow_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]   wr_addr_reg, wr_addr_next;

    entry_t             rd_ent;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   last_pos;
    logic               full;
    logic               match;
    logic [TOTAL_W-1:0] total_less;
    logic               rot_go;
    logic [IDX_W-1:0]   rot_r;

    function automatic out_word_t make_word(
        input logic [KIND_W-1:0]   kind,
        input logic                hit,
        input logic [KEY_W-1:0]    key,
        input logic [HANDLE_W-1:0] handle,
        input logic [TOTAL_W-1:0]  total,
        input logic                last
    );
        out_word_t w;
        w.kind        = kind;
        w.hit         = hit;
        w.key_out     = key;
        w.handle_out  = handle;
        w.total_bytes = total;
        w.last        = last;
        return w;
    endfunction

    assign rd_ent     = entry_t'(ram_rdata);
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign last_pos   = cnt_m1[IDX_W-1:0];
    assign full       = (count_reg == CNT_W'(ENTRIES));
    assign match      = (rd_ent.key == cmd_reg.frame_number);
    assign total_less = total_reg - TOTAL_W'(rd_ent.size);
    assign busy       = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            grow_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
            pos_reg     <= '0;
            wr_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            grow_reg    <= grow_next;
            wr_pend_reg <= wr_pend_next;
            pos_reg     <= pos_next;
            wr_addr_reg <= wr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ent_reg <= ent_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        ent_next     = ent_reg;
        pos_next     = pos_reg;
        grow_next    = grow_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        ram_req      = '0;
        res          = '0;
        rot_go       = 1'b0;
        rot_r        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    grow_next = 1'b0;
                    ent_next  = '{key: cmd.frame_number, size: cmd.frame_bytes,
                                  handle: cmd.frame_handle};
                    unique case (cmd.mode)
                        MODE_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res.valid = 1'b1;
                                res.word  = make_word(KIND_LOOKUP, 1'b0, cmd.frame_number,
                                                      '0, total_reg, 1'b1);
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                pos_next      = '0;
                                state_next    = ST_FIND;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg == '0)
                            begin
                                grow_next  = 1'b1;
                                state_next = ST_PLACE;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                pos_next      = '0;
                                state_next    = ST_FIND;
                            end
                        end
                        MODE_CLEAR, MODE_TRIM:
                        begin
                            state_next = ST_TRIM_CHK;
                        end
                    endcase
                end
            end

            ST_FIND:
            begin
                // rd_ent holds the entry at recency position pos_reg
                priority if (match)
                begin
                    rot_go = 1'b1;
                    rot_r  = pos_reg;
                    res.valid = 1'b1;
                    if (cmd_reg.mode == MODE_LOOKUP)
                    begin
                        ent_next = rd_ent;
                        res.word = make_word(KIND_LOOKUP, 1'b1, cmd_reg.frame_number,
                                             rd_ent.handle, total_reg, 1'b1);
                    end
                    else
                    begin
                        // duplicate key leaves before the new word goes in
                        total_next = total_less;
                        res.word   = make_word(KIND_REMOVED, 1'b0, rd_ent.key,
                                               rd_ent.handle, total_less, 1'b0);
                    end
                end
                else if (pos_reg == last_pos)
                begin
                    if (cmd_reg.mode == MODE_LOOKUP)
                    begin
                        res.valid  = 1'b1;
                        res.word   = make_word(KIND_LOOKUP, 1'b0, cmd_reg.frame_number,
                                               '0, total_reg, 1'b1);
                        state_next = ST_IDLE;
                    end
                    else if (full)
                    begin
                        // full table gives up its least recent entry
                        rot_go     = 1'b1;
                        rot_r      = pos_reg;
                        total_next = total_less;
                        res.valid  = 1'b1;
                        res.word   = make_word(KIND_REMOVED, 1'b0, rd_ent.key,
                                               rd_ent.handle, total_less, 1'b0);
                    end
                    else
                    begin
                        rot_go    = 1'b1;
                        rot_r     = count_reg[IDX_W-1:0];
                        grow_next = 1'b1;
                    end
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = pos_reg + IDX_W'(1);
                    pos_next      = pos_reg + IDX_W'(1);
                end
            end

            ST_ROT:
            begin
                // read position pos_reg, write back the previous one a slot later
                ram_req.re    = 1'b1;
                ram_req.raddr = pos_reg;
                if (wr_pend_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = wr_addr_reg;
                    ram_req.wdata = rd_ent;
                end
                wr_pend_next = 1'b1;
                wr_addr_next = pos_reg + IDX_W'(1);
                if (pos_reg == '0)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    pos_next = pos_reg - IDX_W'(1);
                end
            end

            ST_FLUSH:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = wr_addr_reg;
                ram_req.wdata = rd_ent;
                wr_pend_next  = 1'b0;
                state_next    = ST_PLACE;
            end

            ST_PLACE:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = ent_reg;
                if (grow_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (cmd_reg.mode == MODE_INSERT)
                begin
                    total_next = total_reg + TOTAL_W'(cmd_reg.frame_bytes);
                    state_next = ST_TRIM_CHK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_TRIM_CHK:
            begin
                if ((count_reg != '0) &&
                    ((cmd_reg.mode == MODE_CLEAR) || (total_reg > max_bytes)))
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = last_pos;
                    state_next    = ST_TRIM_EV;
                end
                else
                begin
                    res.valid  = 1'b1;
                    res.word   = make_word(KIND_DONE, 1'b0, '0, '0, total_reg, 1'b1);
                    state_next = ST_IDLE;
                end
            end

            ST_TRIM_EV:
            begin
                total_next = total_less;
                count_next = cnt_m1;
                res.valid  = 1'b1;
                res.word   = make_word(KIND_REMOVED, 1'b0, rd_ent.key, rd_ent.handle,
                                       total_less, 1'b0);
                state_next = ST_TRIM_CHK;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // move positions rot_r-1 .. 0 down by one, then place the word at the front
        if (rot_go)
        begin
            wr_pend_next = 1'b0;
            if (rot_r == '0)
            begin
                state_next = ST_PLACE;
            end
            else
            begin
                pos_next   = rot_r - IDX_W'(1);
                state_next = ST_ROT;
            end
        end
    end

endmodule

FILE: rtl/byte_budget_lru_cache_core.sv
// top level of the byte budget lru cache: register bank, sequencer, entry memory, result stage
// a lookup answers when the walk finds the key or reaches the last entry; on a hit the block
//   stays busy past the end of the search to move the entry to the front
// one command at a time: the walk through the entry memory takes one position per cycle,
//   and each eviction passes through a check state and an eviction state
// results are shown for one cycle each; the receiver cannot stall them
// reset: async, empties the cache and sets max_bytes to all ones; no clearing pass
module byte_budget_lru_cache_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // command side
    input  logic                             start,
    input  bblru_pkg::in_word_t              cmd,
    output logic                             busy,
    // result side
    output logic                             result_valid,
    output bblru_pkg::out_word_t             result,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bblru_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bblru_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bblru_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import bblru_pkg::*;

    logic [TOTAL_W-1:0] max_bytes;
    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    res_t               res;

    logic               result_valid_reg;
    out_word_t          result_reg;

    // byte budget register, read back over apb
    bblru_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_bytes (max_bytes)
    );

    // the sequencer owns entry count and byte total; the memory is indexed by
    // recency position, most recent at position 0, so no slot map is needed
    bblru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .max_bytes (max_bytes),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res       (res)
    );

    // one word per recency position: key, size and handle side by side;
    // positions at or past the entry count are never read, so no initialisation
    bblru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // result stage: each word is held for exactly one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res.word;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/bblru_checker.sv
// port-level assertions for the byte budget lru cache, bound to the top level
`include "byte_budget_lru_cache_core_assert.svh"

module bblru_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 result_valid,
    input  bblru_pkg::out_word_t result
);
    import bblru_pkg::*;

    logic accepted;
    logic mid_word;
    logic done_word;
    logic miss_word;

    assign accepted  = start && !busy;
    assign mid_word  = result_valid && !result.last;
    assign done_word = result_valid && (result.kind == KIND_DONE);
    assign miss_word = result_valid && (result.kind == KIND_LOOKUP) && !result.hit;

    // an accepted command either keeps the block busy or answers at once
    `BBLRU_ASSERT_NEXT(a_accept_busy, accepted, busy || result_valid, "command left no trace")

    // a word that is not the final one is always followed by more work
    `BBLRU_ASSERT_IMPL(a_more_busy, mid_word, busy, "non-final word while idle")

    // done words close the command and carry no hit
    `BBLRU_ASSERT_IMPL(a_done_last, done_word, result.last && !result.hit, "malformed done word")

    // a lookup miss returns a zero handle
    `BBLRU_ASSERT_IMPL(a_miss_handle, miss_word, result.handle_out == '0, "miss with handle")

endmodule

bind byte_budget_lru_cache_core bblru_checker u_bblru_checker (.*);
